### rtl/core/w2u_pkg.sv
// ----------------------------------------------------------------------------
// w2u_pkg
// Types, constants and lookup functions shared by the transcoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package w2u_pkg;

   localparam int RUN_IDX_W = 3;

   localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
   localparam logic [15:0] CP_TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [7:0] BYTE_C1_LIMIT = 8'hA0;

   typedef enum logic [1:0] {
      RUN_ASCII,
      RUN_NULL,
      RUN_TWO,
      RUN_THREE
   } run_kind_type;

   // one classified input byte: what kind of run, its encoded bytes and the end flag
   typedef struct packed {
      run_kind_type    kind;
      logic [2:0][7:0] bytes;
      logic            eos;
   } run_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [RUN_IDX_W-1:0] run_length(input run_kind_type kind);
      logic [RUN_IDX_W-1:0] len;
      case (kind)
         RUN_ASCII: len = RUN_IDX_W'(1);
         RUN_NULL:  len = RUN_IDX_W'(6);
         RUN_TWO:   len = RUN_IDX_W'(2);
         RUN_THREE: len = RUN_IDX_W'(3);
         default:   len = RUN_IDX_W'(1);
      endcase
      return len;
   endfunction

   // backslash, u, 0, 0, 0, 0
   function automatic logic [7:0] null_escape_byte(input logic [RUN_IDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         RUN_IDX_W'(0): b = 8'h5C;
         RUN_IDX_W'(1): b = 8'h75;
         default:       b = 8'h30;
      endcase
      return b;
   endfunction

   // code points for 0x80..0x9F
   function automatic logic [15:0] c1_code_point(input logic [4:0] low);
      logic [15:0] cp;
      case (low)
         5'h00: cp = 16'h20AC;
         5'h01: cp = CP_REPLACEMENT;
         5'h02: cp = 16'h201A;
         5'h03: cp = 16'h0192;
         5'h04: cp = 16'h201E;
         5'h05: cp = 16'h2026;
         5'h06: cp = 16'h2020;
         5'h07: cp = 16'h2021;
         5'h08: cp = 16'h02C6;
         5'h09: cp = 16'h2030;
         5'h0A: cp = 16'h0160;
         5'h0B: cp = 16'h2039;
         5'h0C: cp = 16'h0152;
         5'h0D: cp = CP_REPLACEMENT;
         5'h0E: cp = 16'h017D;
         5'h0F: cp = CP_REPLACEMENT;
         5'h10: cp = CP_REPLACEMENT;
         5'h11: cp = 16'h2018;
         5'h12: cp = 16'h2019;
         5'h13: cp = 16'h201C;
         5'h14: cp = 16'h201D;
         5'h15: cp = 16'h2022;
         5'h16: cp = 16'h2013;
         5'h17: cp = 16'h2014;
         5'h18: cp = 16'h02DC;
         5'h19: cp = 16'h2122;
         5'h1A: cp = 16'h0161;
         5'h1B: cp = 16'h203A;
         5'h1C: cp = 16'h0153;
         5'h1D: cp = CP_REPLACEMENT;
         5'h1E: cp = 16'h017E;
         5'h1F: cp = 16'h0178;
         default: cp = CP_REPLACEMENT;
      endcase
      return cp;
   endfunction

endpackage

`default_nettype wire

### rtl/core/w2u_if.sv
// ----------------------------------------------------------------------------
// w2u_req_if / w2u_rsp_if
// Valid/ready channels for input bytes and for UTF-8 output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface w2u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface w2u_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       string_done;

   modport source (output valid, output out_byte, output last_of_run, output string_done,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_run, input string_done,
                 output ready);
endinterface

`default_nettype wire

### rtl/core/w2u_front.sv
// ----------------------------------------------------------------------------
// w2u_front
// Accepts input bytes, maps them to code points and encodes them as a run.
// ----------------------------------------------------------------------------
`default_nettype none

module w2u_front (
   w2u_req_if.sink                  req_chan,
   input  w2u_pkg::queue_status_type q_stat,
   output logic                     push,
   output w2u_pkg::run_desc_type    push_data
);

   logic [15:0] cp;

   always_comb begin
      req_chan.ready = !q_stat.full;
      push = req_chan.valid && !q_stat.full;
   end

   always_comb begin
      if (req_chan.in_byte < w2u_pkg::BYTE_C1_LIMIT) begin
         cp = w2u_pkg::c1_code_point(req_chan.in_byte[4:0]);
      end else begin
         cp = {8'h00, req_chan.in_byte};
      end

      push_data.eos = req_chan.end_of_string;
      push_data.bytes = '0;
      if (req_chan.in_byte == 8'h00) begin
         push_data.kind = w2u_pkg::RUN_NULL;
      end else if (!req_chan.in_byte[7]) begin
         push_data.kind = w2u_pkg::RUN_ASCII;
         push_data.bytes[0] = req_chan.in_byte;
      end else if (cp < w2u_pkg::CP_TWO_BYTE_LIMIT) begin
         push_data.kind = w2u_pkg::RUN_TWO;
         push_data.bytes[0] = {3'b110, cp[10:6]};
         push_data.bytes[1] = {2'b10, cp[5:0]};
      end else begin
         push_data.kind = w2u_pkg::RUN_THREE;
         push_data.bytes[0] = {4'b1110, cp[15:12]};
         push_data.bytes[1] = {2'b10, cp[11:6]};
         push_data.bytes[2] = {2'b10, cp[5:0]};
      end
   end

endmodule

`default_nettype wire

### rtl/core/w2u_queue.sv
// ----------------------------------------------------------------------------
// w2u_queue
// Short FIFO of encoded runs between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module w2u_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  w2u_pkg::run_desc_type      push_data,
   input  logic                       pop,
   output w2u_pkg::run_desc_type      head_data,
   output w2u_pkg::queue_status_type  q_stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   w2u_pkg::run_desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      head_data = mem_ff[rd_ptr_ff];
      q_stat.full = (count_ff == CNT_W'(DEPTH));
      q_stat.empty = (count_ff == '0);
   end

endmodule

`default_nettype wire

### rtl/core/w2u_back.sv
// ----------------------------------------------------------------------------
// w2u_back
// Sends runs from the queue one byte per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module w2u_back (
   input  logic                      clock,
   input  logic                      reset,
   input  w2u_pkg::run_desc_type     head_data,
   input  w2u_pkg::queue_status_type q_stat,
   output logic                      pop,
   w2u_rsp_if.source                 rsp_chan
);

   localparam int IW = w2u_pkg::RUN_IDX_W;

   logic                  active_ff, active_in;
   w2u_pkg::run_desc_type desc_ff, desc_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  fire;
   logic                  is_last;
   logic                  load;
   logic [7:0]            byte_sel;

   always_comb begin
      fire = active_ff && rsp_chan.ready;
      is_last = (idx_ff == w2u_pkg::run_length(desc_ff.kind) - IW'(1));
      // take the next run once the current one has sent its final byte
      load = !active_ff || (fire && is_last);
      pop = load && !q_stat.empty;

      active_in = active_ff;
      desc_in = desc_ff;
      idx_in = idx_ff;
      if (pop) begin
         active_in = 1'b1;
         desc_in = head_data;
         idx_in = '0;
      end else if (load) begin
         active_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   always_comb begin
      if (desc_ff.kind == w2u_pkg::RUN_NULL) begin
         byte_sel = w2u_pkg::null_escape_byte(idx_ff);
      end else begin
         case (idx_ff)
            IW'(0):  byte_sel = desc_ff.bytes[0];
            IW'(1):  byte_sel = desc_ff.bytes[1];
            default: byte_sel = desc_ff.bytes[2];
         endcase
      end
   end

   always_comb begin
      rsp_chan.valid = active_ff;
      rsp_chan.out_byte = byte_sel;
      rsp_chan.last_of_run = is_last;
      rsp_chan.string_done = is_last && desc_ff.eos;
   end

endmodule

`default_nettype wire

### rtl/core/win1252_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// win1252_to_utf8_transcoder
// Windows-1252 byte stream to UTF-8 byte stream converter.
// ----------------------------------------------------------------------------
// Each accepted byte becomes a run of output bytes: 1 for 0x01..0x7F, 2 or 3
// for 0x80..0xFF (undefined codes give EF BF BD), and the 6-byte escape "\u0000"
// for a zero byte. The last byte of a run carries last_of_run, and string_done
// when the input byte had end_of_string. Output goes one byte per cycle while
// rsp_chan is ready, so plain ASCII streams through at one byte per cycle. The
// first output byte is driven from the back part's run register, which loads
// from the queue entry that the input transfer writes. A QUEUE_DEPTH-entry
// queue of encoded runs sits between the input side and the output serializer,
// so input keeps flowing while a long run drains, until the queue is full.
`default_nettype none

module win1252_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   w2u_req_if.sink    req_chan,
   w2u_rsp_if.source  rsp_chan
);

   logic                      q_push;
   logic                      q_pop;
   w2u_pkg::run_desc_type     q_push_data;
   w2u_pkg::run_desc_type     q_head_data;
   w2u_pkg::queue_status_type q_stat;

   w2u_front u_front (
      .req_chan  (req_chan),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_data (q_push_data)
   );

   w2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head_data),
      .q_stat    (q_stat)
   );

   w2u_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (q_head_data),
      .q_stat    (q_stat),
      .pop       (q_pop),
      .rsp_chan  (rsp_chan)
   );

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.string_done |-> rsp_chan.last_of_run)
      else $error("string_done without last_of_run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run |=> rsp_chan.valid)
      else $error("run stalled before its last byte");

   a_idle_latency: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && q_stat.empty && !rsp_chan.valid
      |-> ##2 rsp_chan.valid)
      else $error("accepted byte did not reach the output in two cycles");

endmodule

`default_nettype wire

### tb/sv/tb_win1252_to_utf8_transcoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_win1252_to_utf8_transcoder
// Self-checking bench: drives Windows-1252 bytes over the request channel
// and checks every UTF-8 output byte against typed runs or a local encoder.
// ----------------------------------------------------------------------------
// A directed table covers the null escape, the ASCII limits, every undefined
// C1 code, two- and three-byte forms and the end-of-string flag. Random bytes
// follow, weighted toward the C1 and Latin-1 ranges, over three idle phases.

module tb_win1252_to_utf8_transcoder;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int ITEMS_PER_PHASE = 52;
   localparam logic [15:0] CP_FFFD = 16'hFFFD;

   // one output byte as the sink sees it
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       string_done;
   } utf8_beat_type;

   // one stimulus row; typed_len of zero means the encoder supplies the bytes
   typedef struct packed {
      logic [7:0]  in_byte;
      logic        eos;
      logic [2:0]  typed_len;
      logic [47:0] typed_seq;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;

   utf8_beat_type utf8_pending_q[$];
   stim_row_type  presented_rows_q[$];
   stim_row_type  directed_rows[$];

   w2u_req_if req_bus ();
   w2u_rsp_if rsp_bus ();

   win1252_to_utf8_transcoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #2 clock = ~clock;

   // Windows-1252 code point of a byte in 0x80..0xFF
   function automatic logic [15:0] cp1252_of(input logic [7:0] b);
      logic [15:0] cp;
      if (b >= 8'hA0) begin
         cp = {8'h00, b};
      end else begin
         case (b)
            8'h80: cp = 16'h20AC;
            8'h82: cp = 16'h201A;
            8'h83: cp = 16'h0192;
            8'h84: cp = 16'h201E;
            8'h85: cp = 16'h2026;
            8'h86: cp = 16'h2020;
            8'h87: cp = 16'h2021;
            8'h88: cp = 16'h02C6;
            8'h89: cp = 16'h2030;
            8'h8A: cp = 16'h0160;
            8'h8B: cp = 16'h2039;
            8'h8C: cp = 16'h0152;
            8'h8E: cp = 16'h017D;
            8'h91: cp = 16'h2018;
            8'h92: cp = 16'h2019;
            8'h93: cp = 16'h201C;
            8'h94: cp = 16'h201D;
            8'h95: cp = 16'h2022;
            8'h96: cp = 16'h2013;
            8'h97: cp = 16'h2014;
            8'h98: cp = 16'h02DC;
            8'h99: cp = 16'h2122;
            8'h9A: cp = 16'h0161;
            8'h9B: cp = 16'h203A;
            8'h9C: cp = 16'h0153;
            8'h9E: cp = 16'h017E;
            8'h9F: cp = 16'h0178;
            default: cp = CP_FFFD;
         endcase
      end
      return cp;
   endfunction

   // encoded run, first byte in the top octet of the result
   function automatic logic [47:0] utf8_run_of(input logic [7:0] b, output int unsigned len);
      logic [15:0] cp;
      logic [47:0] seq;
      seq = '0;
      if (b == 8'h00) begin
         len = 6;
         seq = 48'h5C7530303030;
      end else if (!b[7]) begin
         len = 1;
         seq[47:40] = b;
      end else begin
         cp = cp1252_of(b);
         if (cp < 16'h0800) begin
            len = 2;
            seq[47:40] = {3'b110, cp[10:6]};
            seq[39:32] = {2'b10, cp[5:0]};
         end else begin
            len = 3;
            seq[47:40] = {4'b1110, cp[15:12]};
            seq[39:32] = {2'b10, cp[11:6]};
            seq[31:24] = {2'b10, cp[5:0]};
         end
      end
      return seq;
   endfunction

   task automatic queue_run(input logic [47:0] seq, input int unsigned len, input logic eos);
      utf8_beat_type beat;
      for (int unsigned k = 0; k < len; k++) begin
         beat.out_byte    = seq[47 - 8*k -: 8];
         beat.last_of_run = (k == len - 1);
         beat.string_done = (k == len - 1) ? eos : 1'b0;
         utf8_pending_q.push_back(beat);
      end
   endtask

   function automatic stim_row_type mk_row(input logic [7:0] b, input logic eos,
                                           input logic [2:0] len, input logic [47:0] seq);
      stim_row_type r;
      r.in_byte   = b;
      r.eos       = eos;
      r.typed_len = len;
      r.typed_seq = seq;
      return r;
   endfunction

   function automatic logic [7:0] random_win_byte();
      logic [7:0] b;
      case ($urandom_range(9))
         0:       b = 8'h00;
         1, 2, 3: b = 8'($urandom_range(8'h7F, 8'h01));
         4, 5:    b = 8'h80 + 8'($urandom_range(31));
         6: begin
            case ($urandom_range(4))
               0:       b = 8'h81;
               1:       b = 8'h8D;
               2:       b = 8'h8F;
               3:       b = 8'h90;
               default: b = 8'h9D;
            endcase
         end
         default: b = 8'($urandom_range(8'hFF, 8'hA0));
      endcase
      return b;
   endfunction

   // present one byte; hold valid across back-to-back transfers
   task automatic send_row(input stim_row_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.in_byte       <= r.in_byte;
      req_bus.end_of_string <= r.eos;
      presented_rows_q.push_back(r);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_row(mk_row(random_win_byte(), ($urandom_range(7) == 0), 3'd0, 48'h0));
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // transfer monitor: predict on input, compare on output
   always @(posedge clock) begin
      stim_row_type  row;
      utf8_beat_type got;
      utf8_beat_type want;
      logic [47:0]   seq;
      int unsigned   len;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.out_byte    = rsp_bus.out_byte;
            got.last_of_run = rsp_bus.last_of_run;
            got.string_done = rsp_bus.string_done;
            if (utf8_pending_q.size() == 0) begin
               err_count++;
               $display("%0t: unexpected output byte=%h last=%b done=%b",
                        $time, got.out_byte, got.last_of_run, got.string_done);
            end else begin
               want = utf8_pending_q.pop_front();
               if (got !== want) begin
                  err_count++;
                  $display("%0t: expected byte=%h last=%b done=%b, actual %h/%b/%b",
                           $time, want.out_byte, want.last_of_run, want.string_done,
                           got.out_byte, got.last_of_run, got.string_done);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            row = presented_rows_q.pop_front();
            if (row.typed_len != 3'd0) begin
               queue_run(row.typed_seq, 32'(row.typed_len), req_bus.end_of_string);
            end else begin
               seq = utf8_run_of(req_bus.in_byte, len);
               queue_run(seq, len, req_bus.end_of_string);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_win1252_to_utf8_transcoder: FAIL");
         $finish;
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.in_byte       = 8'h00;
      req_bus.end_of_string = 1'b0;
      rsp_bus.ready         = 1'b0;

      // null escape, ASCII limits, undefined codes, Latin-1 limits, flag on each form
      directed_rows.push_back(mk_row(8'h00, 1'b0, 3'd6, 48'h5C7530303030));
      directed_rows.push_back(mk_row(8'h01, 1'b0, 3'd1, 48'h010000000000));
      directed_rows.push_back(mk_row(8'h7F, 1'b0, 3'd1, 48'h7F0000000000));
      directed_rows.push_back(mk_row(8'h80, 1'b0, 3'd3, 48'hE282AC000000));
      directed_rows.push_back(mk_row(8'h81, 1'b0, 3'd3, 48'hEFBFBD000000));
      directed_rows.push_back(mk_row(8'h8D, 1'b0, 3'd3, 48'hEFBFBD000000));
      directed_rows.push_back(mk_row(8'h8F, 1'b0, 3'd3, 48'hEFBFBD000000));
      directed_rows.push_back(mk_row(8'h90, 1'b0, 3'd3, 48'hEFBFBD000000));
      directed_rows.push_back(mk_row(8'h9D, 1'b1, 3'd3, 48'hEFBFBD000000));
      directed_rows.push_back(mk_row(8'hA0, 1'b0, 3'd2, 48'hC2A000000000));
      directed_rows.push_back(mk_row(8'hFF, 1'b0, 3'd2, 48'hC3BF00000000));
      directed_rows.push_back(mk_row(8'h00, 1'b1, 3'd6, 48'h5C7530303030));
      directed_rows.push_back(mk_row(8'h41, 1'b1, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'h83, 1'b0, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'h88, 1'b0, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'h9F, 1'b1, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'h99, 1'b0, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'h9E, 1'b0, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'hC0, 1'b0, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'hFF, 1'b1, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'h7F, 1'b1, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'h55, 1'b0, 3'd0, 48'h0));
      directed_rows.push_back(mk_row(8'hAA, 1'b1, 3'd0, 48'h0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 10;
      rsp_idle_pct = 60;
      foreach (directed_rows[i])
         send_row(directed_rows[i]);
      send_random(ITEMS_PER_PHASE);

      req_idle_pct = 60;
      rsp_idle_pct = 10;
      send_random(ITEMS_PER_PHASE);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(ITEMS_PER_PHASE);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (utf8_pending_q.size() != 0 || presented_rows_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("tb_win1252_to_utf8_transcoder: PASS");
      else
         $display("tb_win1252_to_utf8_transcoder: FAIL");
      $finish;
   end

endmodule

### files.f
rtl/core/w2u_pkg.sv
rtl/core/w2u_if.sv
rtl/core/w2u_front.sv
rtl/core/w2u_queue.sv
rtl/core/w2u_back.sv
rtl/core/win1252_to_utf8_transcoder.sv
tb/sv/tb_win1252_to_utf8_transcoder.sv
